>>> rtl/bsm_pkg.sv
// shared types and constants for the bank switch mapper
// no dependencies; used by every module under rtl/
`default_nettype none

package bsm_pkg;

  localparam int unsigned PRG_PAGE_BITS = 13;
  localparam int unsigned CHR_PAGE_BITS = 10;
  localparam int unsigned MEM_ADDR_W    = 19;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned UNITS_W       = 6;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [UNITS_W-1:0] UNITS_RESET = 6'd32;

  // bus cycle kinds on the input channel
  typedef enum logic [1:0] {
    MODE_CPU_READ  = 2'd0,
    MODE_CPU_WRITE = 2'd1,
    MODE_PPU_READ  = 2'd2
  } mode_e;

  // configuration register indexes
  typedef enum logic {
    CFG_PRG_UNITS = 1'b0,
    CFG_CHR_UNITS = 1'b1
  } cfg_idx_e;

  // result target codes
  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_PRG_ROM = 2'd1,
    TGT_PRG_RAM = 2'd2,
    TGT_CHR     = 2'd3
  } target_e;

  // what the back end has to do with an item
  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_RAM_READ  = 3'd1,
    OP_RAM_WRITE = 3'd2,
    OP_PRG_READ  = 3'd3,
    OP_REG_WRITE = 3'd4,
    OP_CHR_READ  = 3'd5,
    OP_PPU_CLOCK = 3'd6
  } op_e;

  // mapper register selected by {addr[14:13], addr[0]}
  typedef enum logic [2:0] {
    REG_BANK_SELECT = 3'd0,
    REG_BANK_DATA   = 3'd1,
    REG_MIRROR      = 3'd2,
    REG_RAM_PROTECT = 3'd3,
    REG_IRQ_RELOAD  = 3'd4,
    REG_IRQ_CLEAR   = 3'd5,
    REG_IRQ_DISABLE = 3'd6,
    REG_IRQ_ENABLE  = 3'd7
  } reg_sel_e;

  typedef struct packed {
    op_e         op;
    reg_sel_e    sel;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/bsm_front.sv
// front end: decodes each bus cycle into a back end operation
// depends on bsm_pkg
`default_nettype none

module bsm_front (
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [1:0]     mode_i,
  input  wire logic [15:0]    address_i,
  input  wire logic [7:0]     write_data_i,
  output logic                push_o,
  output bsm_pkg::item_t      item_o,
  input  wire logic           queue_ready_i
);

  logic is_cpu, in_ram, in_rom;

  assign in_ready_o = queue_ready_i;
  assign push_o     = in_valid_i & queue_ready_i;

  assign is_cpu = (mode_i == bsm_pkg::MODE_CPU_READ) || (mode_i == bsm_pkg::MODE_CPU_WRITE);
  assign in_rom = address_i[15];
  assign in_ram = (address_i[15:13] == 3'b011);

  always_comb begin
    item_o.sel  = bsm_pkg::reg_sel_e'({address_i[14:13], address_i[0]});
    item_o.addr = address_i;
    item_o.data = write_data_i;
    item_o.op   = bsm_pkg::OP_NONE;
    if (is_cpu) begin
      if (in_ram) begin
        item_o.op = (mode_i == bsm_pkg::MODE_CPU_WRITE) ? bsm_pkg::OP_RAM_WRITE
                                                         : bsm_pkg::OP_RAM_READ;
      end else if (in_rom) begin
        item_o.op = (mode_i == bsm_pkg::MODE_CPU_WRITE) ? bsm_pkg::OP_REG_WRITE
                                                         : bsm_pkg::OP_PRG_READ;
      end
    end else if (mode_i == bsm_pkg::MODE_PPU_READ) begin
      // above pattern space the read still clocks the counter
      item_o.op = (address_i[15:13] == 3'b000) ? bsm_pkg::OP_CHR_READ
                                               : bsm_pkg::OP_PPU_CLOCK;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bsm_queue.sv
// short queue of decoded items between front and back end
// depends on bsm_pkg
`default_nettype none

module bsm_queue #(
  parameter int unsigned Depth = bsm_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire bsm_pkg::item_t  item_i,
  output logic                 ready_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output bsm_pkg::item_t       item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bsm_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

>>> rtl/bsm_back.sv
// back end: mapper registers, bank mapping, scanline counter and result register
// depends on bsm_pkg
`default_nettype none

module bsm_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [bsm_pkg::UNITS_W-1:0]       prg_units_i,
  input  wire logic [bsm_pkg::UNITS_W-1:0]       chr_units_i,
  input  wire logic                              q_valid_i,
  input  wire bsm_pkg::item_t                    q_item_i,
  output logic                                   q_pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             target_o,
  output logic [bsm_pkg::MEM_ADDR_W-1:0]         mem_address_o,
  output logic                                   ram_write_o,
  output logic                                   irq_line_o,
  output logic                                   mirror_horizontal_o
);

  // prg pages of 8k minus one, size rounded down to a power of two
  function automatic logic [5:0] prg_mask_f(logic [5:0] raw);
    logic [5:0] m;
    priority if (raw[5]) m = 6'd63;
    else if (raw[4])     m = 6'd31;
    else if (raw[3])     m = 6'd15;
    else if (raw[2])     m = 6'd7;
    else if (raw[1])     m = 6'd3;
    else                 m = 6'd1;
    return m;
  endfunction

  // chr pages of 1k minus one
  function automatic logic [7:0] chr_mask_f(logic [5:0] raw);
    logic [7:0] m;
    priority if (raw[5]) m = 8'd255;
    else if (raw[4])     m = 8'd127;
    else if (raw[3])     m = 8'd63;
    else if (raw[2])     m = 8'd31;
    else if (raw[1])     m = 8'd15;
    else                 m = 8'd7;
    return m;
  endfunction

  logic [7:0] bank_regs_q [8];
  logic [2:0] bank_index_q, bank_index_d;
  logic       prg_swap_q, prg_swap_d;
  logic       chr_invert_q, chr_invert_d;
  logic       mirror_q, mirror_d;
  logic [7:0] irq_reload_q, irq_reload_d;
  logic [7:0] irq_count_q, irq_count_d;
  logic       irq_enable_q, irq_enable_d;
  logic       irq_flag_q, irq_flag_d;
  logic       a12_high_q, a12_high_d;

  logic       out_valid_q;
  logic [1:0] target_q, target_d;
  logic [bsm_pkg::MEM_ADDR_W-1:0] mem_addr_q, mem_addr_d;
  logic       ram_write_q, ram_write_d;
  logic       irq_line_q, mirror_out_q;

  logic       bank_we;
  logic [7:0] bank_wdata;

  logic [5:0] prg_mask, prg_page_num;
  logic [7:0] prg_raw;
  logic [7:0] chr_mask, chr_raw, chr_page_num;
  logic [2:0] chr_slot, chr_idx;

  bsm_pkg::item_t it;
  assign it = q_item_i;

  assign q_pop_o = q_valid_i & (~out_valid_q | out_ready_i);

  // prg window select
  always_comb begin
    prg_mask = prg_mask_f(prg_units_i);
    unique case (it.addr[14:13])
      2'd3: prg_raw = {2'b00, prg_mask};
      2'd1: prg_raw = bank_regs_q[7];
      2'd0: prg_raw = prg_swap_q ? {2'b00, prg_mask & 6'h3e} : bank_regs_q[6];
      default: prg_raw = prg_swap_q ? bank_regs_q[6] : {2'b00, prg_mask & 6'h3e};
    endcase
    prg_page_num = prg_raw[5:0] & prg_mask;
  end

  // chr window select: two 2k slots then four 1k slots, swapped by invert
  always_comb begin
    chr_mask = chr_mask_f(chr_units_i);
    chr_slot = it.addr[12:10] ^ {chr_invert_q, 2'b00};
    chr_idx  = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};
    chr_raw  = bank_regs_q[chr_idx];
    if (!chr_slot[2]) begin
      chr_raw = {chr_raw[7:1], chr_slot[0]};
    end
    chr_page_num = chr_raw & chr_mask;
  end

  always_comb begin
    bank_index_d = bank_index_q;
    prg_swap_d   = prg_swap_q;
    chr_invert_d = chr_invert_q;
    mirror_d     = mirror_q;
    irq_reload_d = irq_reload_q;
    irq_count_d  = irq_count_q;
    irq_enable_d = irq_enable_q;
    irq_flag_d   = irq_flag_q;
    a12_high_d   = a12_high_q;
    bank_we      = 1'b0;
    bank_wdata   = it.data;
    target_d     = bsm_pkg::TGT_NONE;
    mem_addr_d   = '0;
    ram_write_d  = 1'b0;

    if (bank_index_q <= 3'd1) begin
      bank_wdata = it.data & 8'hfe;
    end else if (bank_index_q >= 3'd6) begin
      bank_wdata = it.data & 8'h3f;
    end

    unique case (it.op)
      bsm_pkg::OP_RAM_READ, bsm_pkg::OP_RAM_WRITE: begin
        target_d    = bsm_pkg::TGT_PRG_RAM;
        mem_addr_d  = bsm_pkg::MEM_ADDR_W'(it.addr[12:0]);
        ram_write_d = (it.op == bsm_pkg::OP_RAM_WRITE);
      end
      bsm_pkg::OP_PRG_READ: begin
        target_d   = bsm_pkg::TGT_PRG_ROM;
        mem_addr_d = {prg_page_num, it.addr[bsm_pkg::PRG_PAGE_BITS-1:0]};
      end
      bsm_pkg::OP_REG_WRITE: begin
        unique case (it.sel)
          bsm_pkg::REG_BANK_SELECT: begin
            bank_index_d = it.data[2:0];
            prg_swap_d   = it.data[6];
            chr_invert_d = it.data[7];
          end
          bsm_pkg::REG_BANK_DATA:   bank_we = 1'b1;
          bsm_pkg::REG_MIRROR:      mirror_d = it.data[0];
          // protect bits gate nothing on this board
          bsm_pkg::REG_RAM_PROTECT: ;
          bsm_pkg::REG_IRQ_RELOAD:  irq_reload_d = it.data;
          bsm_pkg::REG_IRQ_CLEAR:   irq_count_d = '0;
          bsm_pkg::REG_IRQ_DISABLE: begin
            irq_enable_d = 1'b0;
            irq_flag_d   = 1'b0;
          end
          bsm_pkg::REG_IRQ_ENABLE:  irq_enable_d = 1'b1;
        endcase
      end
      bsm_pkg::OP_CHR_READ, bsm_pkg::OP_PPU_CLOCK: begin
        if (it.op == bsm_pkg::OP_CHR_READ) begin
          target_d   = bsm_pkg::TGT_CHR;
          mem_addr_d = bsm_pkg::MEM_ADDR_W'({chr_page_num,
                                             it.addr[bsm_pkg::CHR_PAGE_BITS-1:0]});
        end
        // rising a12 clocks the scanline counter
        if (it.addr[12] && !a12_high_q) begin
          a12_high_d = 1'b1;
          if (irq_count_q == '0) begin
            irq_count_d = irq_reload_q;
          end else begin
            irq_count_d = irq_count_q - 8'd1;
            if (irq_count_q == 8'd1 && irq_enable_q) begin
              irq_flag_d = 1'b1;
            end
          end
        end else if (!it.addr[12]) begin
          a12_high_d = 1'b0;
        end
      end
      bsm_pkg::OP_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        bank_regs_q[i] <= '0;
      end
      bank_index_q <= '0;
      prg_swap_q   <= 1'b0;
      chr_invert_q <= 1'b0;
      mirror_q     <= 1'b0;
      irq_reload_q <= '0;
      irq_count_q  <= '0;
      irq_enable_q <= 1'b0;
      irq_flag_q   <= 1'b0;
      a12_high_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (q_pop_o) begin
        if (bank_we) begin
          bank_regs_q[bank_index_q] <= bank_wdata;
        end
        bank_index_q <= bank_index_d;
        prg_swap_q   <= prg_swap_d;
        chr_invert_q <= chr_invert_d;
        mirror_q     <= mirror_d;
        irq_reload_q <= irq_reload_d;
        irq_count_q  <= irq_count_d;
        irq_enable_q <= irq_enable_d;
        irq_flag_q   <= irq_flag_d;
        a12_high_q   <= a12_high_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      target_q     <= target_d;
      mem_addr_q   <= mem_addr_d;
      ram_write_q  <= ram_write_d;
      irq_line_q   <= irq_flag_d;
      mirror_out_q <= mirror_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign target_o            = target_q;
  assign mem_address_o       = mem_addr_q;
  assign ram_write_o         = ram_write_q;
  assign irq_line_o          = irq_line_q;
  assign mirror_horizontal_o = mirror_out_q;

  a_write_only_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ram_write_q |-> target_q == bsm_pkg::TGT_PRG_RAM)
    else $error("ram write flagged outside prg ram");

  a_none_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && target_q == bsm_pkg::TGT_NONE |-> mem_addr_q == '0)
    else $error("address set with no target");

  a_irq_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_flag_q) |-> $past(irq_enable_q))
    else $error("irq raised while disabled");

endmodule

`default_nettype wire

>>> rtl/bank_switch_mapper_scanline_irq.sv
// top level of the bank switch mapper with scanline interrupt
// depends on bsm_pkg, bsm_front, bsm_queue, bsm_back
//
// Each input item is one bus cycle: a CPU read, a CPU write or a PPU pattern
// read (mode_i, address_i, write_data_i). Each item gives exactly one result
// item: the memory reached (target_o), the byte address in it, a PRG RAM
// write strobe, and the interrupt and mirroring levels after the access.
// Both channels are valid/ready. The front end decodes an item and puts it
// into a two-entry queue; the back end takes one queued item per cycle
// while the result register is empty or being taken, updates the mapper
// registers and scanline counter, and loads the result register. An accepted
// item is written into the queue, and its result is registered when the back
// end pops it; one item is taken every cycle while results are taken. When the
// receiver stalls the result register holds, the queue fills, and in_ready_o
// drops once both entries are used. Reset clears all mapper state and sets
// both size registers to 32 units. Size registers sit on the APB port at byte
// addresses 0 (PRG 16k units) and 4 (CHR 8k units); the user must write them
// only while the block is idle, and the block itself does not enforce this.
`default_nettype none

module bank_switch_mapper_scanline_irq #(
  parameter int unsigned QueueDepth = bsm_pkg::QUEUE_DEPTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bsm_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [bsm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [bsm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        mode_i,
  input  wire logic [15:0]                       address_i,
  input  wire logic [7:0]                        write_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             target_o,
  output logic [bsm_pkg::MEM_ADDR_W-1:0]         mem_address_o,
  output logic                                   ram_write_o,
  output logic                                   irq_line_o,
  output logic                                   mirror_horizontal_o
);

  logic [bsm_pkg::UNITS_W-1:0] prg_units_q, chr_units_q;
  logic                        cfg_we;
  bsm_pkg::cfg_idx_e           cfg_idx;

  logic           push, queue_ready, q_valid, q_pop;
  bsm_pkg::item_t f_item, q_item;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = bsm_pkg::cfg_idx_e'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      bsm_pkg::CFG_PRG_UNITS: prdata = bsm_pkg::APB_DATA_W'(prg_units_q);
      bsm_pkg::CFG_CHR_UNITS: prdata = bsm_pkg::APB_DATA_W'(chr_units_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_units_q <= bsm_pkg::UNITS_RESET;
      chr_units_q <= bsm_pkg::UNITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bsm_pkg::CFG_PRG_UNITS: prg_units_q <= pwdata[bsm_pkg::UNITS_W-1:0];
        bsm_pkg::CFG_CHR_UNITS: chr_units_q <= pwdata[bsm_pkg::UNITS_W-1:0];
      endcase
    end
  end

  bsm_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .push_o        (push),
    .item_o        (f_item),
    .queue_ready_i (queue_ready)
  );

  bsm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .ready_o (queue_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  bsm_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .prg_units_i         (prg_units_q),
    .chr_units_i         (chr_units_q),
    .q_valid_i           (q_valid),
    .q_item_i            (q_item),
    .q_pop_o             (q_pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .target_o            (target_o),
    .mem_address_o       (mem_address_o),
    .ram_write_o         (ram_write_o),
    .irq_line_o          (irq_line_o),
    .mirror_horizontal_o (mirror_horizontal_o)
  );

endmodule

`default_nettype wire
